>>> rtl/bup_pkg.sv
// Shared types, codes and helpers for the bitmap update parser.
// Used by the parse step, the result queue and the top level.
`timescale 1ns / 1ps

package bup_pkg;

  // Result kinds.
  localparam logic [1:0] EV_HEADER = 2'd0;
  localparam logic [1:0] EV_BODY   = 2'd1;
  localparam logic [1:0] EV_DONE   = 2'd2;
  localparam logic [1:0] EV_ERROR  = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_TYPE     = 2'd0;
  localparam logic [1:0] ERR_LENGTH   = 2'd1;
  localparam logic [1:0] ERR_TRUNC    = 2'd2;
  localparam logic [1:0] ERR_TRAILING = 2'd3;

  // Header word indexes that get special handling.
  localparam logic [3:0] FIELD_NONE      = 4'd0;
  localparam logic [3:0] FIELD_FLAGS     = 4'd7;
  localparam logic [3:0] FIELD_LENGTH    = 4'd8;
  localparam logic [3:0] FIELD_BODY_SIZE = 4'd9;

  // Compression header layout: eight bytes, body size in bytes two and three.
  localparam logic [2:0]  COMP_SIZE_LO  = 3'd2;
  localparam logic [2:0]  COMP_SIZE_HI  = 3'd3;
  localparam logic [2:0]  COMP_LAST     = 3'd7;
  localparam logic [16:0] COMP_HDR_BYTES = 17'd8;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BITMAP_TYPE = 2'd0;
  localparam logic [1:0] CFG_COMP_MASK   = 2'd1;
  localparam logic [1:0] CFG_NOHDR_MASK  = 2'd2;

  localparam logic [15:0] BITMAP_TYPE_RESET = 16'd1;
  localparam logic [15:0] COMP_MASK_RESET   = 16'd1;
  localparam logic [15:0] NOHDR_MASK_RESET  = 16'd1024;

  typedef struct packed {
    logic [15:0] bitmap_type_code;
    logic [15:0] compressed_flag_mask;
    logic [15:0] no_header_flag_mask;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [3:0]  field_index;
    logic [15:0] field_value;
    logic [15:0] rect_number;
    logic [1:0]  error_code;
    logic        rect_end;
    logic        run_last;
  } result_t;

  // Up to two results produced by one input beat, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic result_t make_result(logic [1:0] kind, logic [3:0] idx,
                                          logic [15:0] value, logic [15:0] rect,
                                          logic [1:0] err, logic rend);
    result_t r;
    r.event_kind  = kind;
    r.field_index = idx;
    r.field_value = value;
    r.rect_number = rect;
    r.error_code  = err;
    r.rect_end    = rend;
    r.run_last    = 1'b0;
    return r;
  endfunction

endpackage

>>> rtl/bup_stream_if.sv
// Valid/ready channels of the bitmap update parser: message bytes in,
// parse results out. Depends on nothing else.
`timescale 1ns / 1ps

interface bup_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface bup_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [3:0]  field_index;
  logic [15:0] field_value;
  logic [15:0] rect_number;
  logic [1:0]  error_code;
  logic        rect_end;
  logic        run_last;

  modport source (output valid, output event_kind, output field_index,
                  output field_value, output rect_number, output error_code,
                  output rect_end, output run_last, input ready);
  modport sink (input valid, input event_kind, input field_index,
                input field_value, input rect_number, input error_code,
                input rect_end, input run_last, output ready);
endinterface

>>> rtl/bitmap_update_parser_core.sv
// Bitmap update message parser: byte stream in, header words, body bytes and
// status out. A byte is registered on arrival and parsed once the result
// queue has room; its results pass through a small queue to the output port.
// One byte is taken every cycle while the queue has room. Each byte gives at
// most one result, except the last byte of a message, which gives up to two;
// the output port hands out one result per cycle while the receiver is ready,
// so only a last byte can push results in faster than they leave. The input
// stalls only when the result queue has fewer than two free slots.
// Depends on bup_pkg, bup_stream_if, bup_parse_step and bup_result_fifo.
`timescale 1ns / 1ps

module bitmap_update_parser_core #(
  parameter int unsigned RESULT_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  bup_byte_if.sink      byte_in,
  bup_result_if.source  result_out,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import bup_pkg::*;

  cfg_t             cfg;
  logic             hold_valid;
  logic [7:0]       hold_byte;
  logic             hold_final;
  logic             room;
  logic             step_en;
  logic             in_fire;
  push_t            push;
  result_t          out_data;

  assign step_en         = hold_valid && room;
  assign byte_in.ready   = !hold_valid || room;
  assign in_fire         = byte_in.valid && byte_in.ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bitmap_type_code     <= BITMAP_TYPE_RESET;
      cfg.compressed_flag_mask <= COMP_MASK_RESET;
      cfg.no_header_flag_mask  <= NOHDR_MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BITMAP_TYPE: cfg.bitmap_type_code     <= cfg_data;
        CFG_COMP_MASK:   cfg.compressed_flag_mask <= cfg_data;
        CFG_NOHDR_MASK:  cfg.no_header_flag_mask  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: holds one beat until the parse step takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_fire) begin
      hold_valid <= 1'b1;
    end else if (step_en) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_byte  <= byte_in.data_byte;
      hold_final <= byte_in.final_byte;
    end
  end

  bup_parse_step u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step_en    (step_en),
    .data_byte  (hold_byte),
    .final_byte (hold_final),
    .push       (push)
  );

  bup_result_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_data  (out_data)
  );

  assign result_out.event_kind  = out_data.event_kind;
  assign result_out.field_index = out_data.field_index;
  assign result_out.field_value = out_data.field_value;
  assign result_out.rect_number = out_data.rect_number;
  assign result_out.error_code  = out_data.error_code;
  assign result_out.rect_end    = out_data.rect_end;
  assign result_out.run_last    = out_data.run_last;

endmodule

>>> rtl/bup_parse_step.sv
// Message parse state and the per-byte step logic of the bitmap update parser.
// Depends on bup_pkg for configuration, result and push types.
`timescale 1ns / 1ps

module bup_parse_step (
  input  logic          clk,
  input  logic          rst,
  input  bup_pkg::cfg_t cfg,
  input  logic          step_en,
  input  logic [7:0]    data_byte,
  input  logic          final_byte,
  output bup_pkg::push_t push
);
  import bup_pkg::*;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_COUNT,
    PH_HDR,
    PH_COMP,
    PH_BODY,
    PH_END
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  hdr_index, hdr_index_next;
  logic [2:0]  word_byte_position, word_byte_position_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;
  logic [15:0] rects_total, rects_total_next;
  logic [15:0] rect_counter, rect_counter_next;
  logic [15:0] current_flags, current_flags_next;
  logic [15:0] stated_length, stated_length_next;
  logic [15:0] body_left, body_left_next;
  logic        error_hold, error_hold_next;

  logic [15:0] word;
  logic [15:0] rect_inc;
  logic [15:0] body_dec;
  logic        has_comp_header;
  logic        len_ok;

  assign word     = {data_byte, low_byte_hold};
  assign rect_inc = rect_counter + 16'd1;
  assign body_dec = body_left - 16'd1;
  assign has_comp_header = ((current_flags & cfg.compressed_flag_mask) != 16'd0) &&
                           ((current_flags & cfg.no_header_flag_mask) == 16'd0);
  assign len_ok = ({1'b0, stated_length} == ({1'b0, body_left} + COMP_HDR_BYTES)) ||
                  (stated_length == body_left);

  // Step logic: the action of the current phase, then the end-of-message mark.
  always_comb begin
    logic    p_valid;
    logic    f_valid;
    logic    err;
    logic    finish;
    result_t p;
    result_t f;

    p_valid = 1'b0;
    f_valid = 1'b0;
    err     = 1'b0;
    finish  = 1'b0;
    p       = make_result(EV_HEADER, FIELD_NONE, 16'd0, rect_counter, ERR_TYPE, 1'b0);
    f       = p;

    phase_next              = phase;
    hdr_index_next          = hdr_index;
    word_byte_position_next = word_byte_position;
    low_byte_hold_next      = low_byte_hold;
    rects_total_next        = rects_total;
    rect_counter_next       = rect_counter;
    current_flags_next      = current_flags;
    stated_length_next      = stated_length;
    body_left_next          = body_left;
    error_hold_next         = error_hold;

    if (!error_hold) begin
      case (phase)
        PH_TYPE: begin
          if (!word_byte_position[0]) begin
            low_byte_hold_next      = data_byte;
            word_byte_position_next = 3'd1;
          end else begin
            word_byte_position_next = 3'd0;
            if (word != cfg.bitmap_type_code) begin
              p_valid = 1'b1;
              p = make_result(EV_ERROR, FIELD_NONE, 16'd0, rect_counter, ERR_TYPE, 1'b0);
              err = 1'b1;
            end else begin
              phase_next = PH_COUNT;
            end
          end
        end
        PH_COUNT: begin
          if (!word_byte_position[0]) begin
            low_byte_hold_next      = data_byte;
            word_byte_position_next = 3'd1;
          end else begin
            word_byte_position_next = 3'd0;
            rects_total_next        = word;
            rect_counter_next       = 16'd0;
            hdr_index_next          = 4'd0;
            phase_next              = (word == 16'd0) ? PH_END : PH_HDR;
          end
        end
        PH_HDR: begin
          if (!word_byte_position[0]) begin
            low_byte_hold_next      = data_byte;
            word_byte_position_next = 3'd1;
          end else begin
            word_byte_position_next = 3'd0;
            p_valid = 1'b1;
            if (hdr_index < FIELD_LENGTH) begin
              if (hdr_index == FIELD_FLAGS) begin
                current_flags_next = word;
              end
              p = make_result(EV_HEADER, hdr_index, word, rect_counter, ERR_TYPE, 1'b0);
              hdr_index_next = hdr_index + 4'd1;
            end else begin
              stated_length_next = word;
              if (has_comp_header) begin
                p = make_result(EV_HEADER, FIELD_LENGTH, word, rect_counter,
                                ERR_TYPE, 1'b0);
                phase_next = PH_COMP;
              end else if (word == 16'd0) begin
                p = make_result(EV_HEADER, FIELD_LENGTH, word, rect_counter,
                                ERR_TYPE, 1'b1);
                finish = 1'b1;
              end else begin
                p = make_result(EV_HEADER, FIELD_LENGTH, word, rect_counter,
                                ERR_TYPE, 1'b0);
                body_left_next = word;
                phase_next     = PH_BODY;
              end
            end
          end
        end
        PH_COMP: begin
          if (word_byte_position == COMP_SIZE_LO) begin
            low_byte_hold_next = data_byte;
          end else if (word_byte_position == COMP_SIZE_HI) begin
            body_left_next = word;
          end
          if (word_byte_position == COMP_LAST) begin
            word_byte_position_next = 3'd0;
            p_valid = 1'b1;
            if (!len_ok) begin
              p = make_result(EV_ERROR, FIELD_NONE, 16'd0, rect_counter, ERR_LENGTH, 1'b0);
              err = 1'b1;
            end else if (body_left == 16'd0) begin
              p = make_result(EV_HEADER, FIELD_BODY_SIZE, 16'd0, rect_counter,
                              ERR_TYPE, 1'b1);
              finish = 1'b1;
            end else begin
              p = make_result(EV_HEADER, FIELD_BODY_SIZE, body_left, rect_counter,
                              ERR_TYPE, 1'b0);
              phase_next = PH_BODY;
            end
          end else begin
            word_byte_position_next = word_byte_position + 3'd1;
          end
        end
        PH_BODY: begin
          body_left_next = body_dec;
          p_valid = 1'b1;
          p = make_result(EV_BODY, FIELD_NONE, {8'd0, data_byte}, rect_counter, ERR_TYPE,
                          body_dec == 16'd0);
          finish = (body_dec == 16'd0);
        end
        default: begin
          // A byte after a complete message is trailing.
          p_valid = 1'b1;
          p = make_result(EV_ERROR, FIELD_NONE, 16'd0, rect_counter, ERR_TRAILING, 1'b0);
          err = 1'b1;
        end
      endcase

      // Close the rectangle and move to the next one or to the end.
      if (finish) begin
        rect_counter_next = rect_inc;
        hdr_index_next    = 4'd0;
        phase_next        = (rect_inc == rects_total) ? PH_END : PH_HDR;
      end

      // The last byte reports done or truncation unless it or an earlier byte of the message raised an error.
      if (final_byte && !err) begin
        f_valid = 1'b1;
        if (phase_next == PH_END) begin
          f = make_result(EV_DONE, FIELD_NONE, 16'd0, rect_counter_next, ERR_TYPE, 1'b0);
        end else begin
          f = make_result(EV_ERROR, FIELD_NONE, 16'd0, rect_counter_next, ERR_TRUNC, 1'b0);
        end
      end else if (err && !final_byte) begin
        error_hold_next = 1'b1;
      end
    end

    // The last byte always starts a new message.
    if (final_byte) begin
      phase_next              = PH_TYPE;
      hdr_index_next          = 4'd0;
      word_byte_position_next = 3'd0;
      low_byte_hold_next      = 8'd0;
      rects_total_next        = 16'd0;
      rect_counter_next       = 16'd0;
      current_flags_next      = 16'd0;
      stated_length_next      = 16'd0;
      body_left_next          = 16'd0;
      error_hold_next         = 1'b0;
    end

    // Pack the results in order and mark the last one of the beat.
    f.run_last = 1'b1;
    if (p_valid && f_valid) begin
      push.count  = 2'd2;
      push.first  = p;
      push.second = f;
    end else if (p_valid) begin
      p.run_last  = 1'b1;
      push.count  = 2'd1;
      push.first  = p;
      push.second = p;
    end else if (f_valid) begin
      push.count  = 2'd1;
      push.first  = f;
      push.second = f;
    end else begin
      push.count  = 2'd0;
      push.first  = p;
      push.second = f;
    end
    if (!step_en) begin
      push.count = 2'd0;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_TYPE;
      hdr_index          <= 4'd0;
      word_byte_position <= 3'd0;
      low_byte_hold      <= 8'd0;
      rects_total        <= 16'd0;
      rect_counter       <= 16'd0;
      current_flags      <= 16'd0;
      stated_length      <= 16'd0;
      body_left          <= 16'd0;
      error_hold         <= 1'b0;
    end else if (step_en) begin
      phase              <= phase_next;
      hdr_index          <= hdr_index_next;
      word_byte_position <= word_byte_position_next;
      low_byte_hold      <= low_byte_hold_next;
      rects_total        <= rects_total_next;
      rect_counter       <= rect_counter_next;
      current_flags      <= current_flags_next;
      stated_length      <= stated_length_next;
      body_left          <= body_left_next;
      error_hold         <= error_hold_next;
    end
  end

endmodule

>>> rtl/bup_result_fifo.sv
// Result queue of the bitmap update parser: takes up to two results a cycle
// and delivers one a cycle while out_ready is high. Depends on bup_pkg for the result and push types.
`timescale 1ns / 1ps

module bup_result_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  bup_pkg::push_t   push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output bup_pkg::result_t out_data
);
  import bup_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 2);

  result_t       slots [DEPTH];
  logic [PW-1:0] head, head_next;
  logic [PW-1:0] tail, tail_next;
  logic [PW-1:0] tail_plus1;
  logic [PW-1:0] tail_plus2;
  logic [CW-1:0] count, count_next;
  logic          pop;

  assign out_valid = (count != '0);
  assign out_data  = slots[head];
  assign pop       = out_valid && out_ready;
  assign room      = (count <= ROOM_LIMIT);

  // Pointer arithmetic with wrap at the queue depth.
  always_comb begin
    tail_plus1 = (tail == LAST_SLOT) ? '0 : tail + PW'(1);
    tail_plus2 = (tail_plus1 == LAST_SLOT) ? '0 : tail_plus1 + PW'(1);
    head_next  = pop ? ((head == LAST_SLOT) ? '0 : head + PW'(1)) : head;
    case (push.count)
      2'd1:    tail_next = tail_plus1;
      2'd2:    tail_next = tail_plus2;
      default: tail_next = tail;
    endcase
    count_next = count + CW'(push.count) - CW'(pop);
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[tail] <= push.first;
    end
    if (push.count == 2'd2) begin
      slots[tail_plus1] <= push.second;
    end
  end

  // Queue control.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_update_parser_core: generated update messages go in
// one byte per beat, and every result is predicted by a behavioral parser and checked in order.
// Depends on bup_pkg and the bup_byte_if / bup_result_if interfaces.

module tb_top;
  import bup_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int BYTES_PER_SETTING = 300;
  localparam int NUM_SETTINGS = 6;
  localparam int MAX_RECTS = 3;

  // Parser phases, as the byte stream walks through a message.
  localparam logic [3:0] PH_TYPE       = 4'd0;
  localparam logic [3:0] PH_COUNT      = 4'd1;
  localparam logic [3:0] PH_HDR_FIRST  = 4'd2;
  localparam logic [3:0] PH_HDR_LENGTH = 4'd10;
  localparam logic [3:0] PH_COMP       = 4'd11;
  localparam logic [3:0] PH_BODY       = 4'd12;
  localparam logic [3:0] PH_END        = 4'd13;

  localparam logic [1:0] NO_ERROR = 2'd0;

  typedef enum int {MSG_GOOD, MSG_TRUNC, MSG_TRAILING, MSG_BAD_TYPE, MSG_NOISE} msg_shape_t;

  typedef struct packed {
    logic       drain_first;
    logic [7:0] data;
    logic       last;
  } byte_beat_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  bup_byte_if   byte_if();
  bup_result_if res_if();

  bitmap_update_parser_core uut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_if),
    .result_out (res_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Parser state kept by the testbench, plus the register values it believes in.
  cfg_t        regs_now;
  logic [3:0]  msg_phase;
  logic [2:0]  byte_pos;
  logic [7:0]  low_hold;
  logic [15:0] rects_total;
  logic [15:0] rect_count;
  logic [15:0] cur_flags;
  logic [15:0] stated_len;
  logic [15:0] body_left;
  logic        err_hold;

  result_t     expected_results[$];
  byte_beat_t  pending[$];
  logic [7:0]  msg_bytes[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int hold_served;
  int hold_left;
  int quiet_cycles;
  int fail_count;
  int bytes_sent;
  int messages_sent;
  int results_seen;
  int done_seen;
  int errors_seen;
  logic beat_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_message();
    msg_phase   = PH_TYPE;
    byte_pos    = '0;
    low_hold    = '0;
    rects_total = '0;
    rect_count  = '0;
    cur_flags   = '0;
    stated_len  = '0;
    body_left   = '0;
    err_hold    = 1'b0;
  endfunction

  function automatic void log_result(logic [1:0] kind, logic [3:0] idx, logic [15:0] value,
                                     logic [1:0] code, logic rend);
    result_t r;
    r.event_kind  = kind;
    r.field_index = idx;
    r.field_value = value;
    r.rect_number = rect_count;
    r.error_code  = code;
    r.rect_end    = rend;
    r.run_last    = 1'b0;
    expected_results = {expected_results, r};
  endfunction

  // Little-endian word assembly; returns 1 when the high byte completes the word.
  function automatic logic take_word(input logic [7:0] b, output logic [15:0] w);
    w = '0;
    if (!byte_pos[0]) begin
      low_hold = b;
      byte_pos = 3'd1;
      return 1'b0;
    end
    w = {b, low_hold};
    byte_pos = 3'd0;
    return 1'b1;
  endfunction

  function automatic void close_rect();
    rect_count = rect_count + 16'd1;
    msg_phase  = (rect_count == rects_total) ? PH_END : PH_HDR_FIRST;
  endfunction

  function automatic logic comp_header_follows(logic [15:0] flags, cfg_t c);
    return ((flags & c.compressed_flag_mask) != 16'd0) &&
           ((flags & c.no_header_flag_mask) == 16'd0);
  endfunction

  // Works out the results one accepted byte causes and appends them to the expectations.
  function automatic void parse_byte(logic [7:0] b, logic fin);
    int          first_new;
    logic        raised;
    logic [15:0] w;
    logic [3:0]  idx;
    result_t     r;
    first_new = expected_results.size();
    raised = 1'b0;
    if (err_hold) begin
      if (fin) clear_message();
      return;
    end
    if (msg_phase == PH_TYPE) begin
      if (take_word(b, w)) begin
        if (w != regs_now.bitmap_type_code) begin
          log_result(EV_ERROR, FIELD_NONE, 16'd0, ERR_TYPE, 1'b0);
          raised = 1'b1;
        end else begin
          msg_phase = PH_COUNT;
        end
      end
    end else if (msg_phase == PH_COUNT) begin
      if (take_word(b, w)) begin
        rects_total = w;
        rect_count  = '0;
        msg_phase   = (w == 16'd0) ? PH_END : PH_HDR_FIRST;
      end
    end else if (msg_phase >= PH_HDR_FIRST && msg_phase < PH_HDR_LENGTH) begin
      if (take_word(b, w)) begin
        idx = msg_phase - PH_HDR_FIRST;
        if (idx == FIELD_FLAGS) cur_flags = w;
        log_result(EV_HEADER, idx, w, NO_ERROR, 1'b0);
        msg_phase = msg_phase + 4'd1;
      end
    end else if (msg_phase == PH_HDR_LENGTH) begin
      if (take_word(b, w)) begin
        stated_len = w;
        if (comp_header_follows(cur_flags, regs_now)) begin
          log_result(EV_HEADER, FIELD_LENGTH, w, NO_ERROR, 1'b0);
          msg_phase = PH_COMP;
          byte_pos  = '0;
        end else if (w == 16'd0) begin
          // An empty body closes the rectangle on the length word.
          log_result(EV_HEADER, FIELD_LENGTH, w, NO_ERROR, 1'b1);
          close_rect();
        end else begin
          log_result(EV_HEADER, FIELD_LENGTH, w, NO_ERROR, 1'b0);
          body_left = w;
          msg_phase = PH_BODY;
        end
      end
    end else if (msg_phase == PH_COMP) begin
      if (byte_pos == COMP_SIZE_LO) low_hold = b;
      else if (byte_pos == COMP_SIZE_HI) body_left = {b, low_hold};
      if (byte_pos == COMP_LAST) begin
        byte_pos = '0;
        // The plus-eight form is compared at 17 bits so it cannot wrap.
        if (({1'b0, stated_len} != {1'b0, body_left} + COMP_HDR_BYTES) &&
            (stated_len != body_left)) begin
          log_result(EV_ERROR, FIELD_NONE, 16'd0, ERR_LENGTH, 1'b0);
          raised = 1'b1;
        end else if (body_left == 16'd0) begin
          log_result(EV_HEADER, FIELD_BODY_SIZE, 16'd0, NO_ERROR, 1'b1);
          close_rect();
        end else begin
          log_result(EV_HEADER, FIELD_BODY_SIZE, body_left, NO_ERROR, 1'b0);
          msg_phase = PH_BODY;
        end
      end else begin
        byte_pos = byte_pos + 3'd1;
      end
    end else if (msg_phase == PH_BODY) begin
      body_left = body_left - 16'd1;
      log_result(EV_BODY, FIELD_NONE, {8'd0, b}, NO_ERROR, body_left == 16'd0);
      if (body_left == 16'd0) close_rect();
    end else begin
      // Anything after a complete message is a trailing byte.
      log_result(EV_ERROR, FIELD_NONE, 16'd0, ERR_TRAILING, 1'b0);
      raised = 1'b1;
    end

    if (fin) begin
      if (!raised) begin
        if (msg_phase == PH_END) log_result(EV_DONE, FIELD_NONE, 16'd0, NO_ERROR, 1'b0);
        else log_result(EV_ERROR, FIELD_NONE, 16'd0, ERR_TRUNC, 1'b0);
      end
      clear_message();
    end else if (raised) begin
      err_hold = 1'b1;
    end

    if (expected_results.size() > first_new) begin
      r = expected_results[expected_results.size() - 1];
      r.run_last = 1'b1;
      expected_results[expected_results.size() - 1] = r;
    end
  endfunction

  function automatic void put_word(logic [15:0] w);
    msg_bytes = {msg_bytes, w[7:0], w[15:8]};
  endfunction

  // Builds one message of the given shape against the current registers and queues its bytes.
  function automatic void queue_message(msg_shape_t shape, int max_rects);
    logic [15:0] count;
    logic [15:0] flags;
    logic [15:0] size;
    logic [15:0] len;
    int          rects;
    int          cut;
    byte_beat_t  beat;
    msg_bytes.delete();
    if (shape == MSG_NOISE) begin
      repeat ($urandom_range(1, 6)) msg_bytes = {msg_bytes, 8'($urandom)};
    end else begin
      if (shape == MSG_BAD_TYPE)
        put_word(regs_now.bitmap_type_code ^ 16'($urandom_range(1, 65535)));
      else
        put_word(regs_now.bitmap_type_code);

      if (max_rects == 0) begin
        count = '0;
      end else begin
        case ($urandom_range(0, 9))
          0: count = '0;
          9: count = 16'($urandom_range(max_rects + 1, 65535));
          default: count = 16'($urandom_range(1, max_rects));
        endcase
      end
      put_word(count);
      rects = (count > max_rects) ? max_rects : count;

      for (int i = 0; i < rects; i++) begin
        repeat (7) put_word(16'($urandom));
        flags = 16'($urandom);
        case ($urandom_range(0, 3))
          0: flags = '0;
          1, 2: flags = flags & ~regs_now.no_header_flag_mask;
          default: ;
        endcase
        put_word(flags);
        if (comp_header_follows(flags, regs_now)) begin
          if ($urandom_range(0, 19) == 0) size = 16'($urandom_range(16'hFFF8, 16'hFFFF));
          else size = 16'($urandom_range(0, 6));
          case ($urandom_range(0, 9))
            0: len = 16'($urandom);
            1, 2, 3, 4, 5: len = size;
            default: len = (size > 16'hFFF7) ? size : size + 16'd8;
          endcase
          put_word(len);
          for (int k = 0; k < 8; k++) begin
            if (k == COMP_SIZE_LO) msg_bytes = {msg_bytes, size[7:0]};
            else if (k == COMP_SIZE_HI) msg_bytes = {msg_bytes, size[15:8]};
            else msg_bytes = {msg_bytes, 8'($urandom)};
          end
        end else begin
          case ($urandom_range(0, 29))
            0: len = 16'($urandom);
            1, 2: len = 16'($urandom_range(7, 40));
            default: len = 16'($urandom_range(0, 6));
          endcase
          put_word(len);
          size = len;
        end
        // Huge bodies are cut short; the message then ends truncated.
        repeat ((size > 16'd40) ? 5 : int'(size)) msg_bytes = {msg_bytes, 8'($urandom)};
      end

      if (shape == MSG_BAD_TYPE)
        repeat ($urandom_range(1, 2)) msg_bytes = {msg_bytes, 8'($urandom)};
      if (shape == MSG_TRUNC && msg_bytes.size() > 1) begin
        cut = $urandom_range(1, msg_bytes.size() - 1);
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
      if (shape == MSG_TRAILING)
        repeat ($urandom_range(1, 3)) msg_bytes = {msg_bytes, 8'($urandom)};
    end

    foreach (msg_bytes[k]) begin
      beat.drain_first = 1'b0;
      beat.data        = msg_bytes[k];
      beat.last        = (k == msg_bytes.size() - 1);
      pending = {pending, beat};
    end
  endfunction

  function automatic void check_field(string name, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BITMAP_TYPE: regs_now.bitmap_type_code     = value;
      CFG_COMP_MASK:   regs_now.compressed_flag_mask = value;
      CFG_NOHDR_MASK:  regs_now.no_header_flag_mask  = value;
      default: ;
    endcase
  endtask

  // Waits until every byte is in and every result is out, then lets the pipeline settle.
  task automatic drain_and_settle();
    do @(posedge clk);
    while (pending.size() != 0 || byte_if.valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Byte sender: offers the next queued beat at the falling edge, holding it until taken.
  always @(negedge clk) begin
    byte_beat_t beat;
    if (rst) begin
      byte_if.valid <= 1'b0;
    end else if (beat_taken || !byte_if.valid) begin
      if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
          !(pending[0].drain_first && expected_results.size() != 0)) begin
        beat = pending.pop_front();
        byte_if.valid      <= 1'b1;
        byte_if.data_byte  <= beat.data;
        byte_if.final_byte <= beat.last;
      end else begin
        byte_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure, plus a long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served  <= hold_served + 1;
      hold_left    <= HOLD_CYCLES;
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: checks each result beat against the oldest expectation, then predicts
  // the results of any byte accepted at this edge.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      beat_taken   <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      beat_taken <= byte_if.valid && byte_if.ready;
      if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;

      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (res_if.event_kind == EV_DONE) done_seen++;
        if (res_if.event_kind == EV_ERROR) errors_seen++;
        if (expected_results.size() == 0) begin
          $error("Unexpected result: kind %0d index %0d value %0h, none expected",
                 res_if.event_kind, res_if.field_index, res_if.field_value);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("event_kind", want.event_kind, res_if.event_kind);
          check_field("field_index", want.field_index, res_if.field_index);
          check_field("field_value", want.field_value, res_if.field_value);
          check_field("rect_number", want.rect_number, res_if.rect_number);
          check_field("error_code", want.error_code, res_if.error_code);
          check_field("rect_end", want.rect_end, res_if.rect_end);
          check_field("run_last", want.run_last, res_if.run_last);
        end
      end

      if (byte_if.valid && byte_if.ready) begin
        bytes_sent++;
        if (byte_if.final_byte) messages_sent++;
        parse_byte(byte_if.data_byte, byte_if.final_byte);
      end
    end
  end

  // Stimulus: a few short directed messages, then random messages under six register settings.
  initial begin
    int         r;
    byte_beat_t marked;
    int         mark_at;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = CFG_BITMAP_TYPE;
    cfg_data           = '0;
    byte_if.valid      = 1'b0;
    byte_if.data_byte  = '0;
    byte_if.final_byte = 1'b0;
    res_if.ready       = 1'b0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    hold_requests      = 0;
    hold_served        = 0;
    hold_left          = 0;
    fail_count         = 0;
    bytes_sent         = 0;
    messages_sent      = 0;
    results_seen       = 0;
    done_seen          = 0;
    errors_seen        = 0;
    regs_now.bitmap_type_code     = BITMAP_TYPE_RESET;
    regs_now.compressed_flag_mask = COMP_MASK_RESET;
    regs_now.no_header_flag_mask  = NOHDR_MASK_RESET;
    clear_message();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    fork
      begin
        for (int s = 0; s < NUM_SETTINGS; s++) begin
          if (s > 0) drain_and_settle();
          case (s)
            1: begin
              write_reg(CFG_BITMAP_TYPE, 16'hFFFF);
              write_reg(CFG_COMP_MASK, 16'hFFFF);
              write_reg(CFG_NOHDR_MASK, 16'h0000);
            end
            2: begin
              write_reg(CFG_BITMAP_TYPE, 16'h0000);
              write_reg(CFG_COMP_MASK, 16'h0000);
              write_reg(CFG_NOHDR_MASK, 16'hFFFF);
            end
            3: begin
              write_reg(CFG_BITMAP_TYPE, 16'($urandom));
              write_reg(CFG_COMP_MASK, 16'd1 << $urandom_range(0, 15));
              write_reg(CFG_NOHDR_MASK, 16'd1 << $urandom_range(0, 15));
            end
            4: begin
              write_reg(CFG_BITMAP_TYPE, 16'($urandom));
              write_reg(CFG_COMP_MASK, 16'($urandom));
              write_reg(CFG_NOHDR_MASK, 16'($urandom));
            end
            5: begin
              write_reg(CFG_BITMAP_TYPE, BITMAP_TYPE_RESET);
              write_reg(CFG_COMP_MASK, COMP_MASK_RESET);
              write_reg(CFG_NOHDR_MASK, NOHDR_MASK_RESET);
            end
            default: ;
          endcase
          send_idle_pct = (s < 2) ? 19 : (s < 4) ? 56 : 0;
          recv_idle_pct = (s < 2) ? 56 : (s < 4) ? 19 : 0;

          // Short messages: zero rectangles, wrong type, trailing, truncated, noise.
          if (s == 0) begin
            queue_message(MSG_GOOD, 0);
            queue_message(MSG_BAD_TYPE, 0);
            queue_message(MSG_TRAILING, 0);
            queue_message(MSG_TRUNC, 0);
            queue_message(MSG_NOISE, 0);
          end

          while (pending.size() < BYTES_PER_SETTING) begin
            r = $urandom_range(0, 99);
            queue_message(r < 72 ? MSG_GOOD : r < 82 ? MSG_TRUNC : r < 90 ? MSG_TRAILING :
                          r < 95 ? MSG_BAD_TYPE : MSG_NOISE, MAX_RECTS);
          end

          // Long output stall while bytes keep coming, so the input backs up.
          if (s == 1) hold_requests++;
          // One byte mid-stream waits until every outstanding result has drained.
          if (s == 3) begin
            mark_at = $urandom_range(pending.size() / 3, 2 * pending.size() / 3);
            marked = pending[mark_at];
            marked.drain_first = 1'b1;
            pending[mark_at] = marked;
          end
        end
        drain_and_settle();
      end
      wait (quiet_cycles >= QUIET_LIMIT);
    join_any

    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
    end else begin
      $display("Sent %0d bytes in %0d messages across %0d register settings.",
               bytes_sent, messages_sent, NUM_SETTINGS);
      $display("Checked %0d results: %0d done marks, %0d error reports.",
               results_seen, done_seen, errors_seen);
      if (fail_count == 0) begin
        $display("== PASS ==");
      end else begin
        $display("== FAIL ==");
      end
    end
    $finish;
  end

endmodule
